[src/lirc_pkg.sv]
// ----------------------------------------------------------------------------
// lirc_pkg
// shared types and constants of the rational line intersection core
// ----------------------------------------------------------------------------
package lirc_pkg;

    localparam int NUM_W = 51;
    localparam int DEN_W = 34;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MLOAD = 10'b0000000010,
        ST_MSTEP = 10'b0000000100,
        ST_CHECK = 10'b0000001000,
        ST_ABSN  = 10'b0000010000,
        ST_ABSD  = 10'b0000100000,
        ST_GCD   = 10'b0001000000,
        ST_DIVN  = 10'b0010000000,
        ST_DIVD  = 10'b0100000000,
        ST_SIGN  = 10'b1000000000
    } state_t;

endpackage

[src/lirc_alu.sv]
// ----------------------------------------------------------------------------
// lirc_alu
// shared add/subtract unit with carry out, used for multiply, gcd and divide
// ----------------------------------------------------------------------------
module lirc_alu #(
    parameter int WIDTH = 54
) (
    input  logic [WIDTH-1:0]       a,
    input  logic [WIDTH-1:0]       b,
    input  lirc_pkg::alu_op_t      op,
    output logic [WIDTH-1:0]       res,
    output logic                   carry
);
    import lirc_pkg::*;

    logic [WIDTH:0] sum;
    logic [WIDTH-1:0] b_eff;

    always_comb
    begin
        b_eff = (op == ALU_SUB) ? ~b : b;
        sum   = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, (op == ALU_SUB)};
        res   = sum[WIDTH-1:0];
        carry = sum[WIDTH];
    end

endmodule

[src/line_intersection_rational_core.sv]
// ----------------------------------------------------------------------------
// line_intersection_rational_core
// crossing point of two lines as reduced fractions, one shared adder
// ----------------------------------------------------------------------------
// sequence: shift-and-add product passes for the line terms and a check state, then per
// coordinate the absolute values, a binary gcd and two divides by it (numerator, then
// denominator) and a sign state; parallel lines finish at the check state
// throughput: one beat at a time, busy stays high until done pulses
// done is high for one cycle with the result; the receiver cannot stall
// reset: asynchronous, clears the sequencer and the done strobe
module line_intersection_rational_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_BITS-1:0]       p1_x,
    input  logic signed [COORD_BITS-1:0]       p1_y,
    input  logic signed [COORD_BITS-1:0]       p2_x,
    input  logic signed [COORD_BITS-1:0]       p2_y,
    input  logic signed [COORD_BITS-1:0]       q1_x,
    input  logic signed [COORD_BITS-1:0]       q1_y,
    input  logic signed [COORD_BITS-1:0]       q2_x,
    input  logic signed [COORD_BITS-1:0]       q2_y,
    output logic                               done,
    output logic                               intersects,
    output logic signed [lirc_pkg::NUM_W-1:0]  x_num,
    output logic [lirc_pkg::DEN_W-1:0]         x_den,
    output logic signed [lirc_pkg::NUM_W-1:0]  y_num,
    output logic [lirc_pkg::DEN_W-1:0]         y_den
);
    import lirc_pkg::*;

    localparam int MB = COORD_BITS + 1;
    localparam int W  = 3 * COORD_BITS + 5;
    localparam int AW = W + 1;
    localparam int CW = $clog2(W);

    state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, cx_reg, cy_reg;
    logic signed [COORD_BITS-1:0] ax_next, ay_next, cx_next, cy_next;
    logic signed [MB-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [MB-1:0] a1_next, b1_next, a2_next, b2_next;

    logic [W-1:0] acc_reg, acc_next, mcand_reg, mcand_next;
    logic [MB-1:0] mplier_reg, mplier_next;
    logic [3:0] pass_reg, pass_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic signed [W-1:0] c1_reg, c2_reg, det_reg, xn_reg, yn_reg;
    logic signed [W-1:0] c1_next, c2_next, det_next, xn_next, yn_next;

    logic sel_reg, sel_next, neg_reg, neg_next;
    logic [W-1:0] u_reg, u_next, v_reg, v_next, ns_reg, ns_next, ds_reg, ds_next;
    logic [W-1:0] rem_reg, rem_next, quo_reg, quo_next;

    logic done_reg, done_next, int_reg, int_next;
    logic signed [NUM_W-1:0] xn_out_reg, xn_out_next, yn_out_reg, yn_out_next;
    logic [DEN_W-1:0] xd_out_reg, xd_out_next, yd_out_reg, yd_out_next;

    logic [AW-1:0] alu_a, alu_b, alu_res;
    alu_op_t       alu_op;
    logic          alu_carry;

    logic [W-1:0]        acc_step, quo_step, rem_step;
    logic [AW-1:0]       rem_sh;
    logic signed [W-1:0] num_sel, numv;
    logic                last, pass_sub;

    lirc_alu #(.WIDTH(AW)) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .op    (alu_op),
        .res   (alu_res),
        .carry (alu_carry)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign intersects = int_reg;
    assign x_num      = xn_out_reg;
    assign x_den      = xd_out_reg;
    assign y_num      = yn_out_reg;
    assign y_den      = yd_out_reg;

    always_comb
    begin
        state_next  = state_reg;
        ax_next = ax_reg; ay_next = ay_reg; cx_next = cx_reg; cy_next = cy_reg;
        a1_next = a1_reg; b1_next = b1_reg; a2_next = a2_reg; b2_next = b2_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        pass_next   = pass_reg;
        cnt_next    = cnt_reg;
        c1_next = c1_reg; c2_next = c2_reg; det_next = det_reg;
        xn_next = xn_reg; yn_next = yn_reg;
        sel_next = sel_reg; neg_next = neg_reg;
        u_next = u_reg; v_next = v_reg; ns_next = ns_reg; ds_next = ds_reg;
        rem_next = rem_reg; quo_next = quo_reg;
        done_next   = 1'b0;
        int_next    = int_reg;
        xn_out_next = xn_out_reg; yn_out_next = yn_out_reg;
        xd_out_next = xd_out_reg; yd_out_next = yd_out_reg;

        alu_a  = '0;
        alu_b  = '0;
        alu_op = ALU_ADD;

        last     = (cnt_reg == CW'(MB - 1));
        pass_sub = pass_reg[0] && (pass_reg != 4'd1) && (pass_reg != 4'd3);
        acc_step = acc_reg;
        num_sel  = sel_reg ? yn_reg : xn_reg;
        numv     = signed'(ns_reg);
        rem_sh   = {rem_reg, quo_reg[W-1]};
        rem_step = rem_sh[W-1:0];
        quo_step = {quo_reg[W-2:0], 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ax_next   = p1_x;
                    ay_next   = p1_y;
                    cx_next   = q1_x;
                    cy_next   = q1_y;
                    a1_next   = MB'(p2_y) - MB'(p1_y);
                    b1_next   = MB'(p1_x) - MB'(p2_x);
                    a2_next   = MB'(q2_y) - MB'(q1_y);
                    b2_next   = MB'(q1_x) - MB'(q2_x);
                    pass_next = '0;
                    state_next = ST_MLOAD;
                end
            end

            ST_MLOAD:
            begin
                unique case (pass_reg)
                    4'd0:
                    begin
                        mcand_next = W'(a1_reg); mplier_next = MB'(ax_reg);
                    end
                    4'd1:
                    begin
                        mcand_next = W'(b1_reg); mplier_next = MB'(ay_reg);
                    end
                    4'd2:
                    begin
                        mcand_next = W'(a2_reg); mplier_next = MB'(cx_reg);
                    end
                    4'd3:
                    begin
                        mcand_next = W'(b2_reg); mplier_next = MB'(cy_reg);
                    end
                    4'd4:
                    begin
                        mcand_next = W'(a1_reg); mplier_next = b2_reg;
                    end
                    4'd5:
                    begin
                        mcand_next = W'(a2_reg); mplier_next = b1_reg;
                    end
                    4'd6:
                    begin
                        mcand_next = c1_reg; mplier_next = b2_reg;
                    end
                    4'd7:
                    begin
                        mcand_next = c2_reg; mplier_next = b1_reg;
                    end
                    4'd8:
                    begin
                        mcand_next = c2_reg; mplier_next = a1_reg;
                    end
                    default:
                    begin
                        mcand_next = c1_reg; mplier_next = a2_reg;
                    end
                endcase
                if (!pass_reg[0])
                begin
                    acc_next = '0;
                end
                cnt_next   = '0;
                state_next = ST_MSTEP;
            end

            ST_MSTEP:
            begin
                alu_a  = {1'b0, acc_reg};
                alu_b  = {1'b0, mcand_reg};
                alu_op = (pass_sub ^ last) ? ALU_SUB : ALU_ADD;
                if (mplier_reg[0])
                begin
                    acc_step = alu_res[W-1:0];
                end
                acc_next    = acc_step;
                mcand_next  = {mcand_reg[W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[MB-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (last)
                begin
                    unique case (pass_reg)
                        4'd1:    c1_next  = signed'(acc_step);
                        4'd3:    c2_next  = signed'(acc_step);
                        4'd5:    det_next = signed'(acc_step);
                        4'd7:    xn_next  = signed'(acc_step);
                        4'd9:    yn_next  = signed'(acc_step);
                        default: ;
                    endcase
                    pass_next  = pass_reg + 1'b1;
                    state_next = (pass_reg == 4'd9) ? ST_CHECK : ST_MLOAD;
                end
            end

            ST_CHECK:
            begin
                if (det_reg == '0)
                begin
                    int_next    = 1'b0;
                    xn_out_next = '0;
                    xd_out_next = '0;
                    yn_out_next = '0;
                    yd_out_next = '0;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    sel_next   = 1'b0;
                    state_next = ST_ABSN;
                end
            end

            ST_ABSN:
            begin
                alu_b    = {1'b0, num_sel};
                alu_op   = ALU_SUB;
                neg_next = num_sel[W-1] ^ det_reg[W-1];
                u_next   = num_sel[W-1] ? alu_res[W-1:0] : num_sel;
                ns_next  = u_next;
                state_next = ST_ABSD;
            end

            ST_ABSD:
            begin
                alu_b   = {1'b0, det_reg};
                alu_op  = ALU_SUB;
                v_next  = det_reg[W-1] ? alu_res[W-1:0] : det_reg;
                ds_next = v_next;
                state_next = ST_GCD;
            end

            ST_GCD:
            begin
                alu_a  = {1'b0, u_reg};
                alu_b  = {1'b0, v_reg};
                alu_op = ALU_SUB;
                priority if (u_reg == '0)
                begin
                    quo_next   = ns_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVN;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next  = u_reg >> 1;
                    v_next  = v_reg >> 1;
                    ns_next = ns_reg >> 1;
                    ds_next = ds_reg >> 1;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (alu_carry)
                begin
                    u_next = alu_res[W:1];
                end
                else
                begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end

            ST_DIVN, ST_DIVD:
            begin
                alu_a  = rem_sh;
                alu_b  = {1'b0, v_reg};
                alu_op = ALU_SUB;
                if (alu_carry)
                begin
                    rem_step = alu_res[W-1:0];
                    quo_step[0] = 1'b1;
                end
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    rem_next = '0;
                    cnt_next = '0;
                    if (state_reg == ST_DIVN)
                    begin
                        ns_next    = quo_step;
                        quo_next   = ds_reg;
                        state_next = ST_DIVD;
                    end
                    else
                    begin
                        ds_next    = quo_step;
                        state_next = ST_SIGN;
                    end
                end
            end

            ST_SIGN:
            begin
                alu_b  = {1'b0, ns_reg};
                alu_op = ALU_SUB;
                if (neg_reg)
                begin
                    numv = signed'(alu_res[W-1:0]);
                end
                if (!sel_reg)
                begin
                    xn_out_next = NUM_W'(numv);
                    xd_out_next = DEN_W'(ds_reg);
                    sel_next    = 1'b1;
                    state_next  = ST_ABSN;
                end
                else
                begin
                    yn_out_next = NUM_W'(numv);
                    yd_out_next = DEN_W'(ds_reg);
                    int_next    = 1'b1;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= ax_next; ay_reg <= ay_next; cx_reg <= cx_next; cy_reg <= cy_next;
        a1_reg <= a1_next; b1_reg <= b1_next; a2_reg <= a2_next; b2_reg <= b2_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        pass_reg   <= pass_next;
        cnt_reg    <= cnt_next;
        c1_reg <= c1_next; c2_reg <= c2_next; det_reg <= det_next;
        xn_reg <= xn_next; yn_reg <= yn_next;
        sel_reg <= sel_next; neg_reg <= neg_next;
        u_reg <= u_next; v_reg <= v_next; ns_reg <= ns_next; ds_reg <= ds_next;
        rem_reg <= rem_next; quo_reg <= quo_next;
        int_reg    <= int_next;
        xn_out_reg <= xn_out_next; xd_out_reg <= xd_out_next;
        yn_out_reg <= yn_out_next; yd_out_reg <= yd_out_next;
    end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// regression of the rational line intersection core: directed and random
// point sets are driven as start beats, every done beat is compared field by
// field against an exact-fraction prediction computed in wide integers
// ----------------------------------------------------------------------------
module testbench;

    import lirc_pkg::*;

    localparam int CB       = 16;
    localparam int N_RANDOM = 1830;
    localparam int WD_LIMIT = 40000;

    typedef struct {
        logic signed [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy;
        int                   gap;
        bit                   drain;
    } lines_t;

    typedef struct {
        logic                    hit;
        logic signed [NUM_W-1:0] xn;
        logic [DEN_W-1:0]        xd;
        logic signed [NUM_W-1:0] yn;
        logic [DEN_W-1:0]        yd;
    } crossing_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [CB-1:0] p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y;
    logic done;
    logic intersects;
    logic signed [NUM_W-1:0] x_num, y_num;
    logic [DEN_W-1:0] x_den, y_den;

    lines_t    pending_lines[$];
    crossing_t expected_crossings[$];
    int        errors;
    int        n_sent;
    int        n_hits;
    int        n_parallel;
    int        idle_cycles;
    int        wait_left;
    bit        stim_done;

    line_intersection_rational_core #(.COORD_BITS(CB)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .p1_x(p1_x), .p1_y(p1_y), .p2_x(p2_x), .p2_y(p2_y),
        .q1_x(q1_x), .q1_y(q1_y), .q2_x(q2_x), .q2_y(q2_y),
        .done(done), .intersects(intersects),
        .x_num(x_num), .x_den(x_den), .y_num(y_num), .y_den(y_den)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic void lowest_terms(longint num, longint den,
                                         output logic signed [NUM_W-1:0] rn,
                                         output logic [DEN_W-1:0] rd);
        bit neg;
        longint unsigned n, d, g;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        g   = gcd_of(n, d);
        if (g == 0)
            g = 1;
        n  = n / g;
        d  = d / g;
        rn = NUM_W'(neg ? -longint'(n) : longint'(n));
        rd = DEN_W'(d);
    endfunction

    function automatic crossing_t predict_crossing(lines_t l);
        crossing_t r;
        longint a1, b1, c1, a2, b2, c2, det;
        a1  = longint'(l.by) - l.ay;
        b1  = longint'(l.ax) - l.bx;
        c1  = a1 * l.ax + b1 * l.ay;
        a2  = longint'(l.dy) - l.cy;
        b2  = longint'(l.cx) - l.dx;
        c2  = a2 * l.cx + b2 * l.cy;
        det = a1 * b2 - a2 * b1;
        r   = '{1'b0, '0, '0, '0, '0};
        if (det != 0)
        begin
            r.hit = 1'b1;
            lowest_terms(b2 * c1 - b1 * c2, det, r.xn, r.xd);
            lowest_terms(a1 * c2 - a2 * c1, det, r.yn, r.yd);
        end
        return r;
    endfunction

    function automatic logic signed [CB-1:0] pick_coord(int mode);
        case (mode)
            0: return CB'($urandom);
            1: return CB'($signed($urandom_range(0, 40)) - 20);
            2: return $urandom_range(0, 1) ? 16'sh7fff - CB'($urandom_range(0, 3))
                                           : 16'sh8000 + CB'($urandom_range(0, 3));
            default: return CB'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic queue_lines(input logic signed [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy,
                               input bit drain);
        lines_t l;
        l.ax = ax; l.ay = ay; l.bx = bx; l.by = by;
        l.cx = cx; l.cy = cy; l.dx = dx; l.dy = dy;
        l.gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        l.drain = drain;
        pending_lines.push_back(l);
    endtask

    initial
    begin
        int   mode, kind;
        logic signed [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy;
        logic signed [CB-1:0] mx, mn;
        mx = 16'sh7fff;
        mn = 16'sh8000;
        queue_lines(0, 0, 4, 4, 0, 4, 4, 0, 0);
        queue_lines(0, 0, 1, 1, 0, 1, 1, 2, 0);
        queue_lines(0, 0, 1, 1, 2, 2, 5, 5, 0);
        queue_lines(3, 3, 3, 3, 0, 1, 5, 2, 0);
        queue_lines(0, 0, 2, 0, 1, 1, 1, 5, 0);
        queue_lines(0, 0, 3, 1, 0, 1, 1, 0, 0);
        queue_lines(-1, -1, 2, 2, -5, 1, 1, -5, 0);
        queue_lines(mn, mn, mx, mx, mn, mx, mx, mn, 0);
        queue_lines(mx, mn, mn, mx, mn, mn, mx, mx, 0);
        queue_lines(mn, mn, mx, mn, mn, mn, mn, mx, 0);
        queue_lines(mn, mx, mx, mn, mx, mn, mn, mx, 0);
        queue_lines(mn, 0, mx, 1, 0, mn, 1, mx, 1);
        queue_lines(mx, mx, mx - 16'sd1, mn, mn, mn + 16'sd1, mx, mx - 16'sd1, 0);
        queue_lines(-16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd5, -16'sd7, -16'sd3, 16'sd9, 0);
        queue_lines(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 0, 0, 16'sh1234, 16'sh4321, 0);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            mode = $urandom_range(0, 3);
            kind = $urandom_range(0, 9);
            ax = pick_coord(mode); ay = pick_coord(mode);
            bx = pick_coord(mode); by = pick_coord(mode);
            cx = pick_coord(mode); cy = pick_coord(mode);
            dx = pick_coord(mode); dy = pick_coord(mode);
            if (kind == 0)
            begin
                // parallel: second line is the first shifted
                cx = ax + 16'sd3; cy = ay - 16'sd2;
                dx = bx + 16'sd3; dy = by - 16'sd2;
            end
            else if (kind == 1)
            begin
                bx = ax; by = ay;
            end
            queue_lines(ax, ay, bx, by, cx, cy, dx, dy, (i % 600) == 300);
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            wait_left <= 0;
            n_sent    <= 0;
            {p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y} <= '0;
        end
        else if (start && !busy)
        begin
            start <= 1'b0;
            if (pending_lines.size() > 0)
                wait_left <= pending_lines[0].gap;
        end
        else if (!start && pending_lines.size() > 0)
        begin
            if (wait_left > 0)
                wait_left <= wait_left - 1;
            else if (!pending_lines[0].drain || expected_crossings.size() == 0)
            begin
                lines_t l;
                l = pending_lines.pop_front();
                p1_x <= l.ax; p1_y <= l.ay; p2_x <= l.bx; p2_y <= l.by;
                q1_x <= l.cx; q1_y <= l.cy; q2_x <= l.dx; q2_y <= l.dy;
                expected_crossings.push_back(predict_crossing(l));
                start  <= 1'b1;
                n_sent <= n_sent + 1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            crossing_t e;
            if (expected_crossings.size() == 0)
            begin
                $display("%0t: unexpected result beat", $time);
                errors++;
            end
            else
            begin
                e = expected_crossings.pop_front();
                if (e.hit) n_hits++; else n_parallel++;
                if (intersects !== e.hit)
                begin
                    $display("%0t: intersects exp %0d got %0d", $time, e.hit, intersects);
                    errors++;
                end
                if (x_num !== e.xn)
                begin
                    $display("%0t: x_num exp %0d got %0d", $time, e.xn, x_num);
                    errors++;
                end
                if (x_den !== e.xd)
                begin
                    $display("%0t: x_den exp %0d got %0d", $time, e.xd, x_den);
                    errors++;
                end
                if (y_num !== e.yn)
                begin
                    $display("%0t: y_num exp %0d got %0d", $time, e.yn, y_num);
                    errors++;
                end
                if (y_den !== e.yd)
                begin
                    $display("%0t: y_den exp %0d got %0d", $time, e.yd, y_den);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding",
                     expected_crossings.size());
            $display("line_intersection_rational_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        n_hits      = 0;
        n_parallel  = 0;
        idle_cycles = 0;
        stim_done   = 1'b0;
        rst_n       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        wait (pending_lines.size() == 0 && !start);
        wait (expected_crossings.size() == 0);
        repeat (50) @(posedge clk);
        $display("sent %0d point sets: %0d crossings, %0d parallel or degenerate",
                 n_sent, n_hits, n_parallel);
        if (errors == 0 && expected_crossings.size() == 0)
            $display("line_intersection_rational_core regression: pass");
        else
            $display("line_intersection_rational_core regression: fail");
        $finish;
    end

endmodule

[files.f]
src/lirc_pkg.sv
src/lirc_alu.sv
src/line_intersection_rational_core.sv
verif/testbench.sv
